// ===== rtl/core/ugli_pkg.sv =====
// shared types, constants and codes for the uniform grid linear interpolator
package ugli_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ENTRY_IDX_W = 8;
  localparam int unsigned ENTRIES_W   = 9;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int unsigned ADDR_W    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PROD_W    = 2 * WORD_W;
  localparam int unsigned GRID_W    = PROD_W - 2 * FRAC_BITS;
  localparam int unsigned DIST_W    = PROD_W - FRAC_BITS;
  localparam int unsigned DIST_LO_W = (DIST_W + 1) / 2;
  localparam int unsigned DIST_HI_W = DIST_W - DIST_LO_W;
  localparam int unsigned PSUM_W    = WORD_W + DIST_W;
  localparam int unsigned SLOPE_Q_W = PROD_W - FRAC_BITS;
  localparam int unsigned INC_W     = WORD_W + 1;
  localparam int unsigned VAL_W     = WORD_W + 3;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0]    ONE_Q         = WORD_W'(1 << FRAC_BITS);
  localparam logic [WORD_W-1:0]    WORD_MAX      = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic [WORD_W-1:0]    WORD_MIN      = {1'b1, {(WORD_W - 1){1'b0}}};
  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = ENTRIES_W'(TABLE_DEPTH);

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    REGION_INSIDE = 2'd0,
    REGION_BELOW  = 2'd1,
    REGION_ABOVE  = 2'd2
  } region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ORIGIN   = 2'd0,
    CFG_INV_BIN_WIDTH = 2'd1,
    CFG_ENTRIES_USED  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    mode_e                   mode;
    logic [ENTRY_IDX_W-1:0]  entry_index;
    logic signed [WORD_W-1:0] entry_value;
    logic signed [WORD_W-1:0] sample_x;
  } ugli_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] slope;
    region_e                  region;
    logic                     saturated;
  } ugli_out_t;

  typedef struct packed {
    logic [WORD_W-1:0]    grid_origin;
    logic [WORD_W-1:0]    inv_bin_width;
    logic [ENTRIES_W-1:0] entries_used;
  } ugli_cfg_t;

  // classified word handed from the front to the back
  typedef struct packed {
    mode_e             mode;
    logic              wr_en;
    region_e           region;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [DIST_W-1:0] grid_dist;
    logic [WORD_W-1:0] wr_data;
  } ugli_op_t;

endpackage

// ===== rtl/core/ugli_ram.sv =====
// generic single write port ram with registered read
module ugli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ugli_front.sv =====
// front end: takes input words, maps x to grid units and classifies the region
module ugli_front import ugli_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ugli_cfg_t cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ugli_in_t  in_word_i,
  output logic      push_o,
  output ugli_op_t  op_o,
  input  logic      full_i
);

  logic              advance;
  logic              valid1_q, valid2_q, valid3_q;
  ugli_in_t          word1_q, word2_q, word3_q;
  logic [WORD_W-1:0] dx_mag2_q;
  logic              dx_neg2_q, dx_neg3_q;
  logic [PROD_W-1:0] m3_q;

  logic [WORD_W:0]    dx;
  logic [WORD_W:0]    dx_abs;
  logic [PROD_W-1:0]  prod;
  logic [CNT_W-1:0]   n_used;
  logic [ADDR_W-1:0]  last_idx;
  logic [GRID_W-1:0]  m_hi;
  logic [FRAC_BITS-1:0] m_frac;
  logic [ADDR_W-1:0]  k_idx;
  logic               is_zero;
  logic               above;
  logic               below;

  // the whole front moves together, held only when its last word cannot enter the queue
  assign advance    = !(valid3_q && full_i);
  assign in_stall_o = !advance;
  assign push_o     = valid3_q && !full_i;

  assign dx = {word1_q.sample_x[WORD_W-1], word1_q.sample_x}
            - {cfg_i.grid_origin[WORD_W-1], cfg_i.grid_origin};
  assign dx_abs = dx[WORD_W] ? (~dx + 1'b1) : dx;
  assign prod   = PROD_W'(dx_mag2_q) * PROD_W'(cfg_i.inv_bin_width);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (advance) begin
      valid1_q <= in_valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      word1_q   <= in_word_i;
      word2_q   <= word1_q;
      dx_mag2_q <= dx_abs[WORD_W-1:0];
      dx_neg2_q <= dx[WORD_W];
      word3_q   <= word2_q;
      m3_q      <= prod;
      dx_neg3_q <= dx_neg2_q;
    end
  end

  // entry count clamped to the table
  always_comb begin
    priority if (32'(cfg_i.entries_used) < 32'd2) begin
      n_used = CNT_W'(2);
    end else if (32'(cfg_i.entries_used) > TABLE_DEPTH) begin
      n_used = CNT_W'(TABLE_DEPTH);
    end else begin
      n_used = CNT_W'(cfg_i.entries_used);
    end
  end

  assign last_idx = ADDR_W'(n_used - CNT_W'(1));
  assign m_hi     = m3_q[PROD_W-1 -: GRID_W];
  assign m_frac   = m3_q[2*FRAC_BITS-1 -: FRAC_BITS];
  assign k_idx    = m_hi[ADDR_W-1:0];
  assign is_zero  = (m3_q == '0);
  // the low bits of the last grid point are zero, so only the integer part is compared
  assign above    = !dx_neg3_q && (m_hi >= GRID_W'(last_idx));
  assign below    = dx_neg3_q || is_zero;

  always_comb begin
    op_o         = '0;
    op_o.mode    = word3_q.mode;
    op_o.wr_en   = 32'(word3_q.entry_index) < TABLE_DEPTH;
    op_o.wr_data = word3_q.entry_value;
    priority if (word3_q.mode == MODE_WRITE) begin
      op_o.addr_a = ADDR_W'(word3_q.entry_index);
    end else if (above) begin
      op_o.region    = REGION_ABOVE;
      op_o.addr_a    = last_idx - ADDR_W'(1);
      op_o.addr_b    = last_idx;
      op_o.grid_dist = {m_hi - GRID_W'(last_idx), m_frac};
    end else if (below) begin
      op_o.region    = REGION_BELOW;
      op_o.addr_a    = '0;
      op_o.addr_b    = ADDR_W'(1);
      op_o.grid_dist = m3_q[PROD_W-1:FRAC_BITS];
    end else begin
      op_o.region    = REGION_INSIDE;
      op_o.addr_a    = k_idx;
      op_o.addr_b    = k_idx + ADDR_W'(1);
      op_o.grid_dist = {{GRID_W{1'b0}}, m_frac};
    end
  end

endmodule

// ===== rtl/core/ugli_queue.sv =====
// short fifo of classified words between front and back
module ugli_queue import ugli_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ugli_op_t op_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output ugli_op_t head_o
);

  ugli_op_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ===== rtl/core/ugli_back.sv =====
// back end: table access, segment blend, slope and saturation
module ugli_back import ugli_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ugli_cfg_t cfg_i,
  input  logic      head_valid_i,
  input  ugli_op_t  head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ugli_out_t out_word_o
);

  logic              back_en;
  logic              tbl_we;
  logic [WORD_W-1:0] rd_a, rd_b;

  // stage 1: table words arriving
  logic              b1_valid_q;
  region_e           b1_region_q;
  logic [DIST_W-1:0] b1_dist_q;

  // stage 2: segment
  logic              b2_valid_q;
  region_e           b2_region_q;
  logic [DIST_W-1:0] b2_dist_q;
  logic [WORD_W-1:0] b2_mag_q;
  logic              b2_seg_neg_q;
  logic              b2_dir_neg_q;
  logic [WORD_W-1:0] b2_base_q;

  // stage 3: products
  logic                        b3_valid_q;
  region_e                     b3_region_q;
  logic                        b3_seg_neg_q;
  logic                        b3_dir_neg_q;
  logic [WORD_W-1:0]           b3_base_q;
  logic [WORD_W+DIST_LO_W-1:0] b3_p_lo_q;
  logic [WORD_W+DIST_HI_W-1:0] b3_p_hi_q;
  logic [PROD_W-1:0]           b3_p_slope_q;

  // stage 4: offset and slope
  logic              b4_valid_q;
  region_e           b4_region_q;
  logic              b4_dir_neg_q;
  logic [WORD_W-1:0] b4_base_q;
  logic [INC_W-1:0]  b4_inc_q;
  logic              b4_inc_big_q;
  logic [WORD_W-1:0] b4_slope_q;
  logic              b4_slope_clip_q;

  logic      out_valid_q;
  ugli_out_t out_word_q;
  ugli_out_t out_word_d;

  logic [WORD_W:0]             seg;
  logic [WORD_W:0]             seg_abs;
  logic [WORD_W+DIST_LO_W-1:0] p_lo;
  logic [WORD_W+DIST_HI_W-1:0] p_hi;
  logic [PROD_W-1:0]           p_slope;
  logic [PSUM_W-1:0]           psum;
  logic [SLOPE_Q_W-1:0]        q_slope;
  logic                        slope_clip;
  logic [WORD_W-1:0]           slope_val;
  logic [VAL_W-1:0]            base_ext;
  logic [VAL_W-1:0]            inc_ext;
  logic [VAL_W-1:0]            val;
  logic                        val_over, val_under;

  // everything behind the queue freezes while a finished word waits
  assign back_en = !(out_valid_q && out_stall_i);
  assign pop_o   = back_en && head_valid_i;
  assign tbl_we  = pop_o && (head_i.mode == MODE_WRITE) && head_i.wr_en;

  // two copies of the table so both neighbours come out in the same cycle
  ugli_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(head_i.addr_a),
    .wdata_i(head_i.wr_data),
    .re_i   (back_en),
    .raddr_i(head_i.addr_a),
    .rdata_o(rd_a)
  );

  ugli_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(head_i.addr_a),
    .wdata_i(head_i.wr_data),
    .re_i   (back_en),
    .raddr_i(head_i.addr_b),
    .rdata_o(rd_b)
  );

  assign seg     = {rd_b[WORD_W-1], rd_b} - {rd_a[WORD_W-1], rd_a};
  assign seg_abs = seg[WORD_W] ? (~seg + 1'b1) : seg;

  assign p_lo    = (WORD_W + DIST_LO_W)'(b2_mag_q)
                 * (WORD_W + DIST_LO_W)'(b2_dist_q[DIST_LO_W-1:0]);
  assign p_hi    = (WORD_W + DIST_HI_W)'(b2_mag_q)
                 * (WORD_W + DIST_HI_W)'(b2_dist_q[DIST_W-1:DIST_LO_W]);
  assign p_slope = PROD_W'(b2_mag_q) * PROD_W'(cfg_i.inv_bin_width);

  assign psum    = {b3_p_hi_q, {DIST_LO_W{1'b0}}} + PSUM_W'(b3_p_lo_q);
  assign q_slope = b3_p_slope_q[PROD_W-1:FRAC_BITS];

  always_comb begin
    if (b3_seg_neg_q) begin
      slope_clip = (|q_slope[SLOPE_Q_W-1:WORD_W])
                || (q_slope[WORD_W-1] && (|q_slope[WORD_W-2:0]));
      slope_val  = slope_clip ? WORD_MIN : (~q_slope[WORD_W-1:0] + 1'b1);
    end else begin
      slope_clip = |q_slope[SLOPE_Q_W-1:WORD_W-1];
      slope_val  = slope_clip ? WORD_MAX : q_slope[WORD_W-1:0];
    end
  end

  assign base_ext  = {{(VAL_W - WORD_W){b4_base_q[WORD_W-1]}}, b4_base_q};
  assign inc_ext   = {{(VAL_W - INC_W){1'b0}}, b4_inc_q};
  assign val       = b4_dir_neg_q ? (base_ext - inc_ext) : (base_ext + inc_ext);
  assign val_over  = !val[VAL_W-1] && (|val[VAL_W-2:WORD_W-1]);
  assign val_under = val[VAL_W-1] && !(&val[VAL_W-2:WORD_W-1]);

  always_comb begin
    out_word_d.region = b4_region_q;
    // an offset this large leaves the word range whatever the base
    priority if (b4_inc_big_q) begin
      out_word_d.value     = b4_dir_neg_q ? WORD_MIN : WORD_MAX;
      out_word_d.saturated = 1'b1;
    end else if (val_over) begin
      out_word_d.value     = WORD_MAX;
      out_word_d.saturated = 1'b1;
    end else if (val_under) begin
      out_word_d.value     = WORD_MIN;
      out_word_d.saturated = 1'b1;
    end else begin
      out_word_d.value     = val[WORD_W-1:0];
      out_word_d.saturated = b4_slope_clip_q;
    end
    out_word_d.slope = b4_slope_q;
    if (b4_slope_clip_q) begin
      out_word_d.saturated = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      b4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (back_en) begin
      b1_valid_q  <= head_valid_i && (head_i.mode == MODE_QUERY);
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= b2_valid_q;
      b4_valid_q  <= b3_valid_q;
      out_valid_q <= b4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      b1_region_q     <= head_i.region;
      b1_dist_q       <= head_i.grid_dist;

      b2_region_q     <= b1_region_q;
      b2_dist_q       <= b1_dist_q;
      b2_mag_q        <= seg_abs[WORD_W-1:0];
      b2_seg_neg_q    <= seg[WORD_W];
      b2_dir_neg_q    <= seg[WORD_W] ^ (b1_region_q == REGION_BELOW);
      b2_base_q       <= (b1_region_q == REGION_ABOVE) ? rd_b : rd_a;

      b3_region_q     <= b2_region_q;
      b3_seg_neg_q    <= b2_seg_neg_q;
      b3_dir_neg_q    <= b2_dir_neg_q;
      b3_base_q       <= b2_base_q;
      b3_p_lo_q       <= p_lo;
      b3_p_hi_q       <= p_hi;
      b3_p_slope_q    <= p_slope;

      b4_region_q     <= b3_region_q;
      b4_dir_neg_q    <= b3_dir_neg_q;
      b4_base_q       <= b3_base_q;
      b4_inc_q        <= psum[FRAC_BITS +: INC_W];
      b4_inc_big_q    <= |psum[PSUM_W-1:FRAC_BITS+INC_W];
      b4_slope_q      <= slope_val;
      b4_slope_clip_q <= slope_clip;

      out_word_q      <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/core/uniform_grid_linear_interpolator.sv =====
// Piecewise-linear lookup over a uniform grid of Q16.16 table words.
// Input channel (in_valid_i / in_stall_o / in_word_i): a word with mode write
// stores entry_value at entry_index and gives no result; a word with mode
// query gives one result: value, slope, region and a saturation flag.
// Output channel (out_valid_o / out_stall_i / out_word_o) carries the results
// in the order the queries were taken.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (grid origin, inverse bin width, entries in use); write it only while idle.
// Throughput: one word per cycle while the output is not stalled, set by
// the single read per table copy and one pass through the multiplier stage.
// Stall: the output register holds its word and the back pipeline freezes;
// the front keeps taking words into a 4-entry queue, then raises in_stall_o.
// Reset: configuration returns to origin 0, inverse width 1.0 and 256 entries,
// and the pipeline empties. Table contents are undefined until written, so
// queries must only touch entries that were written.
module uniform_grid_linear_interpolator import ugli_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ugli_in_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ugli_out_t            out_word_o
);

  ugli_cfg_t cfg_q;
  logic      q_push, q_full, q_pop, q_head_valid;
  ugli_op_t  q_op, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_origin   <= '0;
      cfg_q.inv_bin_width <= ONE_Q;
      cfg_q.entries_used  <= ENTRIES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GRID_ORIGIN:   cfg_q.grid_origin   <= cfg_wdata_i;
        CFG_INV_BIN_WIDTH: cfg_q.inv_bin_width <= cfg_wdata_i;
        CFG_ENTRIES_USED:  cfg_q.entries_used  <= cfg_wdata_i[ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  ugli_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i (in_word_i),
    .push_o    (q_push),
    .op_o      (q_op),
    .full_i    (q_full)
  );

  ugli_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .op_i        (q_op),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_valid_o(q_head_valid),
    .head_o      (q_head)
  );

  ugli_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_valid_i(q_head_valid),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef NO_ASSERTIONS
  // the front never offers a word the queue cannot hold
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("queue pushed while full");

  // the back only takes words that are there
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_head_valid)
    else $error("queue popped while empty");

  // input back-pressure only ever comes from a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> q_full)
    else $error("input stalled with room in the queue");
`endif

endmodule
